### hdl/rtcsc_pkg.sv
// ----------------------------------------------------------------------------
// rtcsc_pkg
// Shared types and constants for the RTC smooth-calibration ppm converter.
// ----------------------------------------------------------------------------
package rtcsc_pkg;

  localparam logic signed [9:0] PpmMin = -10'sd488;
  localparam logic signed [9:0] PpmMax = 10'sd487;

  localparam int unsigned RemW = 30;  // dividend / partial remainder width
  localparam int unsigned DenW = 22;  // divisor width
  localparam int unsigned QuoW = 10;  // quotient width, quotient always < 2^QuoW

  localparam int unsigned StageBits = 2;
  localparam int unsigned NumDivStages = QuoW / StageBits;

  localparam logic [RemW-1:0] PlusNum   = 30'd512000000;  // 512 * 1e6
  localparam logic [DenW-1:0] Million   = 22'd1000000;
  localparam logic [20:0]     TwoMillion = 21'd2000000;
  localparam logic [20:0]     Window    = 21'd1048576;
  localparam logic [9:0]      PlusPulses = 10'd512;

  typedef enum logic {
    MODE_PPM_TO_CAL = 1'b0,
    MODE_CAL_TO_PPM = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] ppm_in;
    logic               plus_in;
    logic [8:0]         pulse_count_in;
  } in_t;

  typedef struct packed {
    logic signed [9:0] ppm_out;
    logic              plus_out;
    logic [8:0]        pulse_count_out;
  } out_t;

  // Item in flight through the divider pipeline
  typedef struct packed {
    mode_e             mode;
    logic              neg;
    logic              plus;
    logic [8:0]        cnt;
    logic signed [9:0] ppm;
    logic [RemW-1:0]   rem;
    logic [DenW-1:0]   den;
    logic [QuoW-1:0]   quo;
  } work_t;

endpackage

### hdl/rtcsc_prep.sv
// ----------------------------------------------------------------------------
// rtcsc_prep
// Clamps the request and forms dividend and divisor for either direction.
// ----------------------------------------------------------------------------
module rtcsc_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rtcsc_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rtcsc_pkg::work_t out_data_o
);

  logic             valid_q;
  rtcsc_pkg::work_t data_q, data_d;

  always_comb begin
    logic signed [9:0] p;
    logic [8:0]        p9;
    logic [8:0]        a9;
    logic              pos;
    logic [9:0]        mag;
    logic [20:0]       d;

    if (in_data_i.ppm_in < 16'(rtcsc_pkg::PpmMin)) begin
      p = rtcsc_pkg::PpmMin;
    end else if (in_data_i.ppm_in > 16'(rtcsc_pkg::PpmMax)) begin
      p = rtcsc_pkg::PpmMax;
    end else begin
      p = in_data_i.ppm_in[9:0];
    end
    pos = !p[9] && (p != 10'sd0);
    p9  = p[8:0];
    a9  = 9'(-p);

    // mode 1 numerator magnitude and window length
    if (in_data_i.plus_in) begin
      mag = rtcsc_pkg::PlusPulses - 10'(in_data_i.pulse_count_in);
      d   = rtcsc_pkg::Window + 21'(in_data_i.pulse_count_in) - 21'(rtcsc_pkg::PlusPulses);
    end else begin
      mag = 10'(in_data_i.pulse_count_in);
      d   = rtcsc_pkg::Window + 21'(in_data_i.pulse_count_in);
    end

    data_d      = '0;
    data_d.mode = in_data_i.mode;
    data_d.ppm  = p;
    if (in_data_i.mode == rtcsc_pkg::MODE_CAL_TO_PPM) begin
      data_d.plus = in_data_i.plus_in;
      data_d.cnt  = in_data_i.pulse_count_in;
      data_d.neg  = !in_data_i.plus_in && (in_data_i.pulse_count_in != 9'd0);
      // round half away from zero: (2e6*mag + d) / (2d)
      data_d.rem  = 30'(30'(mag) * 30'(rtcsc_pkg::TwoMillion)) + 30'(d);
      data_d.den  = {d, 1'b0};
    end else if (pos) begin
      data_d.plus = 1'b1;
      // p * 1048064 = p*2^20 - p*2^9
      data_d.rem  = rtcsc_pkg::PlusNum - ((30'(p9) << 20) - (30'(p9) << 9));
      data_d.den  = rtcsc_pkg::Million + 22'(p9);
    end else begin
      data_d.plus = 1'b0;
      data_d.rem  = 30'(a9) << 20;
      data_d.den  = rtcsc_pkg::Million - 22'(a9);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hdl/rtcsc_div_stage.sv
// ----------------------------------------------------------------------------
// rtcsc_div_stage
// One registered slice of the restoring divider: StageBits quotient bits.
// ----------------------------------------------------------------------------
module rtcsc_div_stage #(
  parameter int unsigned FirstBit = rtcsc_pkg::QuoW - 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rtcsc_pkg::work_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rtcsc_pkg::work_t out_data_o
);

  logic             valid_q;
  rtcsc_pkg::work_t data_q, data_d;

  always_comb begin
    logic [31:0] sub;
    data_d = in_data_i;
    for (int j = 0; j < int'(rtcsc_pkg::StageBits); j++) begin
      sub = 32'(data_d.den) << (FirstBit - j);
      if (32'(data_d.rem) >= sub) begin
        data_d.rem              = data_d.rem - sub[rtcsc_pkg::RemW-1:0];
        data_d.quo[FirstBit-j]  = 1'b1;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hdl/rtcsc_post.sv
// ----------------------------------------------------------------------------
// rtcsc_post
// Signs and clamps the quotient in cal-to-ppm mode; registers the result.
// ----------------------------------------------------------------------------
module rtcsc_post (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rtcsc_pkg::work_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rtcsc_pkg::out_t  out_data_o
);

  logic            valid_q;
  rtcsc_pkg::out_t data_q, data_d;

  always_comb begin
    logic signed [9:0] q;
    if (in_data_i.neg) begin
      if (in_data_i.quo > 10'd488) begin
        q = rtcsc_pkg::PpmMin;
      end else begin
        q = -$signed(in_data_i.quo);
      end
    end else begin
      if (in_data_i.quo > 10'd487) begin
        q = rtcsc_pkg::PpmMax;
      end else begin
        q = $signed(in_data_i.quo);
      end
    end

    if (in_data_i.mode == rtcsc_pkg::MODE_CAL_TO_PPM) begin
      data_d.ppm_out         = q;
      data_d.plus_out        = in_data_i.plus;
      data_d.pulse_count_out = in_data_i.cnt;
    end else begin
      data_d.ppm_out         = in_data_i.ppm;
      data_d.plus_out        = in_data_i.plus;
      data_d.pulse_count_out = in_data_i.quo[8:0];
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### hdl/rtc_smooth_calibration_ppm_convert.sv
// ----------------------------------------------------------------------------
// rtc_smooth_calibration_ppm_convert
// An input transaction passes through the registers prep, 5 divider slices and
// output register. Throughput: one transaction per cycle while out_ready_i
// does not stall the pipeline; the 10-bit quotient is resolved 2 bits per slice.
// Reset clears only the stage valid flags; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
module rtc_smooth_calibration_ppm_convert (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rtcsc_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rtcsc_pkg::out_t out_data_o
);

  localparam int unsigned N = rtcsc_pkg::NumDivStages;

  logic             valid[N+1];
  logic             ready[N+1];
  rtcsc_pkg::work_t data[N+1];

  rtcsc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (valid[0]),
    .out_ready_i (ready[0]),
    .out_data_o  (data[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_div
    rtcsc_div_stage #(
      .FirstBit (rtcsc_pkg::QuoW - 1 - g * rtcsc_pkg::StageBits)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[g]),
      .in_ready_o  (ready[g]),
      .in_data_i   (data[g]),
      .out_valid_o (valid[g+1]),
      .out_ready_i (ready[g+1]),
      .out_data_o  (data[g+1])
    );
  end

  rtcsc_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid[N]),
    .in_ready_o  (ready[N]),
    .in_data_i   (data[N]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
